>>> hw/rtl/circle_segment_intersection_test_defines.svh
// assertion macros for the checker file
`ifndef CIRCLE_SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define CIRCLE_SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CSIT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, quiet during reset
`define CSIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// next-cycle implication that also holds across reset
`define CSIT_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hw/rtl/csit_pkg.sv
// package: default formats and width helpers for the circle/segment test
`default_nettype none

package csit_pkg;

  localparam int CSIT_COORD_WIDTH    = 24;
  localparam int CSIT_DIR_FRAC_BITS  = 14;
  localparam int CSIT_DIR_WIDTH      = 16;
  localparam int CSIT_RAD_TRIM       = 4;

  function automatic int csit_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // width of p = (dr . dir) >>> dir_frac_bits
  function automatic int csit_p_width(input int cw, input int dfb);
    return (cw + 1) + CSIT_DIR_WIDTH + 1 - dfb;
  endfunction

  // signed width of the discriminant
  function automatic int csit_disc_width(input int cw, input int dfb);
    int pw;
    pw = csit_p_width(cw, dfb);
    return csit_max(2 * pw, 2 * (cw + 1) + 2) + 1;
  endfunction

  // even width of the non-negative radicand fed to the root pipeline
  function automatic int csit_root_in_width(input int cw, input int dfb);
    int dw;
    dw = csit_disc_width(cw, dfb);
    return 2 * (dw / 2);
  endfunction

  localparam int CSIT_DEF_ROOT_IN_WIDTH =
    csit_root_in_width(CSIT_COORD_WIDTH, CSIT_DIR_FRAC_BITS);
  localparam int CSIT_DEF_SIDE_WIDTH =
    1 + CSIT_COORD_WIDTH + csit_p_width(CSIT_COORD_WIDTH, CSIT_DIR_FRAC_BITS);

endpackage

`default_nettype wire

>>> hw/rtl/csit_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, with side data
`default_nettype none

module csit_sqrt_pipe #(
  parameter int RAD_WIDTH  = csit_pkg::CSIT_DEF_ROOT_IN_WIDTH,
  parameter int SIDE_WIDTH = csit_pkg::CSIT_DEF_SIDE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [RAD_WIDTH-1:0]    in_rad,
  input  logic [SIDE_WIDTH-1:0]   in_side,
  output logic                    out_vld,
  output logic [RAD_WIDTH/2-1:0]  out_root,
  output logic [SIDE_WIDTH-1:0]   out_side
);

  localparam int ROOT_WIDTH = RAD_WIDTH / 2;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;

  typedef struct packed {
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
    logic [RAD_WIDTH-1:0]  rad;
  } stage_t;

  function automatic stage_t sqrt_step(input stage_t s);
    stage_t               o;
    logic [REM_WIDTH-1:0] cur;
    logic [REM_WIDTH-1:0] trial;
    logic                 take;
    cur    = {s.rem[REM_WIDTH-3:0], s.rad[RAD_WIDTH-1 -: 2]};
    trial  = {s.root, 2'b01};
    take   = (cur >= trial);
    o.rem  = take ? (cur - trial) : cur;
    o.root = {s.root[ROOT_WIDTH-2:0], take};
    o.rad  = {s.rad[RAD_WIDTH-3:0], 2'b00};
    return o;
  endfunction

  stage_t                st_r    [ROOT_WIDTH];
  stage_t                st_nxt  [ROOT_WIDTH];
  logic [SIDE_WIDTH-1:0] side_r  [ROOT_WIDTH];
  logic [ROOT_WIDTH-1:0] vld_r;
  stage_t                st_first;

  always_comb begin
    st_first.rem  = '0;
    st_first.root = '0;
    st_first.rad  = in_rad;
    st_nxt[0]     = sqrt_step(st_first);
    for (int g = 1; g < ROOT_WIDTH; g++) begin
      st_nxt[g] = sqrt_step(st_r[g-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_WIDTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int g = 0; g < ROOT_WIDTH; g++) begin
        st_r[g] <= st_nxt[g];
      end
      for (int g = 1; g < ROOT_WIDTH; g++) begin
        side_r[g] <= side_r[g-1];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_WIDTH-1];
  assign out_root = st_r[ROOT_WIDTH-1].root;
  assign out_side = side_r[ROOT_WIDTH-1];

endmodule

`default_nettype wire

>>> hw/rtl/circle_segment_intersection_test.sv
// Circle / segment crossing test. One query per transfer on the in_ channel: segment
// start, unit direction, length, circle centre and radius; one out_touching bit per
// query, in order. A new query is taken every clock cycle while the pipeline is not
// stalled. The path runs through six front stages for the difference, the products,
// the dot product and |dr|^2, the split p*p, its recombination and the discriminant,
// then one stage per root bit of the square root (R = half the even radicand width,
// 28 at the default formats), then the output register. When out_ready is low
// with a result waiting, the whole pipeline holds and in_ready drops in that cycle.
`default_nettype none

module circle_segment_intersection_test #(
  parameter int COORD_WIDTH   = csit_pkg::CSIT_COORD_WIDTH,
  parameter int DIR_FRAC_BITS = csit_pkg::CSIT_DIR_FRAC_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [COORD_WIDTH-1:0]                in_seg_start_x,
  input  logic signed [COORD_WIDTH-1:0]                in_seg_start_y,
  input  logic signed [csit_pkg::CSIT_DIR_WIDTH-1:0]   in_dir_x,
  input  logic signed [csit_pkg::CSIT_DIR_WIDTH-1:0]   in_dir_y,
  input  logic        [COORD_WIDTH-1:0]                in_seg_length,
  input  logic signed [COORD_WIDTH-1:0]                in_centre_x,
  input  logic signed [COORD_WIDTH-1:0]                in_centre_y,
  input  logic [COORD_WIDTH-csit_pkg::CSIT_RAD_TRIM-1:0] in_circle_radius,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic                                         out_touching
);

  import csit_pkg::*;

  localparam int DIRW   = CSIT_DIR_WIDTH;
  localparam int DRW    = COORD_WIDTH + 1;
  localparam int RADW   = COORD_WIDTH - CSIT_RAD_TRIM;
  localparam int DPW    = DRW + DIRW;
  localparam int DOTW   = DPW + 1;
  localparam int PW     = csit_p_width(COORD_WIDTH, DIR_FRAC_BITS);
  localparam int PL     = (PW + 1) / 2;
  localparam int PH     = PW - PL;
  localparam int P2W    = 2 * PW;
  localparam int SQW    = 2 * DRW;
  localparam int QW     = 2 * DRW + 2;
  localparam int DW     = csit_disc_width(COORD_WIDTH, DIR_FRAC_BITS);
  localparam int SRW    = csit_root_in_width(COORD_WIDTH, DIR_FRAC_BITS);
  localparam int RTW    = SRW / 2;
  localparam int SIDEW  = 1 + COORD_WIDTH + PW;
  localparam int AW     = csit_max(csit_max(RTW + 1, PW), COORD_WIDTH + 1) + 1;
  localparam int FRONT  = 6;

  logic             en;
  logic [FRONT-1:0] vld_r;

  // stage 1: offsets from the centre
  logic signed [DRW-1:0]         drx_r, dry_r, drx_nxt, dry_nxt;
  logic signed [DIRW-1:0]        dirx_r, diry_r;
  logic [RADW-1:0]               rad_r;
  logic [COORD_WIDTH-1:0]        len1_r, len2_r, len3_r, len4_r, len5_r, len6_r;

  // stage 2: products
  logic signed [DPW-1:0]         dotx_r, doty_r, dotx_nxt, doty_nxt;
  logic signed [SQW-1:0]         sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [2*RADW-1:0]             radsq_r, radsq_nxt;

  // stage 3: p and radius^2 - |dr|^2
  logic signed [DOTW-1:0]        dot_sum, dot_shf;
  logic signed [PW-1:0]          p3_r, p4_r, p5_r, p6_r, p3_nxt;
  logic signed [QW-1:0]          q3_r, q4_r, q5_r, q3_nxt;

  // stage 4: split square of |p|
  logic [PW-1:0]                 p_bits, p_mag;
  logic [PL-1:0]                 p_lo;
  logic [PH-1:0]                 p_hi;
  logic [2*PL-1:0]               pp_ll_r, pp_ll_nxt;
  logic [PH+PL-1:0]              pp_hl_r, pp_hl_nxt;
  logic [2*PH-1:0]               pp_hh_r, pp_hh_nxt;

  // stage 5: p^2
  logic [P2W-1:0]                p2_r, p2_nxt;

  // stage 6: discriminant
  logic signed [DW-1:0]          disc_r, disc_nxt;

  // root pipeline and output
  logic                          sq_vld;
  logic [RTW-1:0]                sq_root;
  logic [SIDEW-1:0]              sq_side;
  logic                          sq_neg;
  logic [COORD_WIDTH-1:0]        sq_len;
  logic signed [PW-1:0]          sq_p;
  logic signed [AW-1:0]          root_x, p_x, len_x, a1, a2;
  logic                          on1, on2;
  logic                          touch_nxt;
  logic                          out_valid_r, out_touching_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[FRONT-2:0], in_valid};
    end
  end

  always_comb begin
    drx_nxt   = DRW'(in_seg_start_x) - DRW'(in_centre_x);
    dry_nxt   = DRW'(in_seg_start_y) - DRW'(in_centre_y);

    dotx_nxt  = drx_r * dirx_r;
    doty_nxt  = dry_r * diry_r;
    sqx_nxt   = drx_r * drx_r;
    sqy_nxt   = dry_r * dry_r;
    radsq_nxt = rad_r * rad_r;

    dot_sum   = DOTW'(dotx_r) + DOTW'(doty_r);
    dot_shf   = dot_sum >>> DIR_FRAC_BITS;
    p3_nxt    = dot_shf[PW-1:0];
    q3_nxt    = QW'(signed'({1'b0, radsq_r})) - QW'(sqx_r) - QW'(sqy_r);

    p_bits    = p3_r;
    p_mag     = p_bits[PW-1] ? (~p_bits + PW'(1)) : p_bits;
    p_lo      = p_mag[PL-1:0];
    p_hi      = p_mag[PW-1:PL];
    pp_ll_nxt = p_lo * p_lo;
    pp_hl_nxt = p_hi * p_lo;
    pp_hh_nxt = p_hi * p_hi;

    p2_nxt    = {pp_hh_r, (2 * PL)'(0)} + P2W'({pp_hl_r, (PL + 1)'(0)}) + P2W'(pp_ll_r);

    disc_nxt  = DW'(signed'({1'b0, p2_r})) + DW'(q5_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drx_r   <= drx_nxt;
      dry_r   <= dry_nxt;
      dirx_r  <= in_dir_x;
      diry_r  <= in_dir_y;
      rad_r   <= in_circle_radius;
      len1_r  <= in_seg_length;

      dotx_r  <= dotx_nxt;
      doty_r  <= doty_nxt;
      sqx_r   <= sqx_nxt;
      sqy_r   <= sqy_nxt;
      radsq_r <= radsq_nxt;
      len2_r  <= len1_r;

      p3_r    <= p3_nxt;
      q3_r    <= q3_nxt;
      len3_r  <= len2_r;

      pp_ll_r <= pp_ll_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      p4_r    <= p3_r;
      q4_r    <= q3_r;
      len4_r  <= len3_r;

      p2_r    <= p2_nxt;
      p5_r    <= p4_r;
      q5_r    <= q4_r;
      len5_r  <= len4_r;

      disc_r  <= disc_nxt;
      p6_r    <= p5_r;
      len6_r  <= len5_r;
    end
  end

  csit_sqrt_pipe #(
    .RAD_WIDTH  (SRW),
    .SIDE_WIDTH (SIDEW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[FRONT-1]),
    .in_rad   (SRW'(disc_r[DW-2:0])),
    .in_side  ({disc_r[DW-1], len6_r, p6_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // crossing distances -p + s and -p - s against (0, length]
  always_comb begin
    sq_neg    = sq_side[SIDEW-1];
    sq_len    = sq_side[SIDEW-2:PW];
    sq_p      = sq_side[PW-1:0];
    root_x    = AW'(signed'({1'b0, sq_root}));
    p_x       = AW'(sq_p);
    len_x     = AW'(signed'({1'b0, sq_len}));
    a1        = root_x - p_x;
    a2        = -p_x - root_x;
    on1       = !a1[AW-1] && (a1 != '0) && (a1 <= len_x);
    on2       = !a2[AW-1] && (a2 != '0) && (a2 <= len_x);
    touch_nxt = !sq_neg && (on1 || on2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_touching_r <= touch_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_touching = out_touching_r;

endmodule

`default_nettype wire

>>> hw/rtl/csit_port_checker.sv
// port-level checks for the circle/segment test, bound to the top level
`default_nettype none

`include "circle_segment_intersection_test_defines.svh"

module csit_port_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic out_valid,
  input  logic out_ready,
  input  logic out_touching
);

  // nothing leaves the pipeline in the cycle after reset
  `CSIT_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // with no result waiting the input side never stalls
  `CSIT_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // a stalled result freezes the whole pipeline, so no transfer is taken
  `CSIT_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !(in_valid && in_ready))

  // a stalled result stays put
  `CSIT_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_touching))

endmodule

bind circle_segment_intersection_test csit_port_checker u_csit_port_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_touching (out_touching)
);

`default_nettype wire
